[hdl/bba_pkg.sv]
`default_nettype none
package bba_pkg;

  // bitmap geometry
  localparam int unsigned MAX_BLOCKS = 4096;
  localparam int unsigned MAP_BYTES  = (MAX_BLOCKS + 7) / 8;
  localparam int unsigned ADDR_W     = $clog2(MAP_BYTES);
  localparam int unsigned IDX_W      = ADDR_W + 3;

  // field widths
  localparam int unsigned SECTOR_W   = 32;
  localparam int unsigned SPB_W      = 7;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned PROD_W     = IDX_W + SPB_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // divider
  localparam int unsigned DIV_STEPS  = SECTOR_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic OP_ALLOC    = 1'b0;
  localparam logic OP_FREE     = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_SECTOR      = 2'd0,
    CFG_SECTORS_PER_BLOCK = 2'd1,
    CFG_BLOCK_COUNT       = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic                operation;
    logic [SECTOR_W-1:0] block_sector;
  } req_t;

  typedef struct packed {
    logic                status;
    logic [SECTOR_W-1:0] allocated_sector;
  } rsp_t;

  // position of the lowest clear bit; meaningless for 8'hFF
  function automatic logic [2:0] lowest_zero(input logic [7:0] v);
    logic [2:0] pos;
    pos = '0;
    for (int b = 7; b >= 0; b--) begin
      if (!v[b]) pos = 3'(b);
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

[hdl/bba_ram.sv]
`default_nettype none
module bba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

[hdl/bba_divider.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module bba_divider (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [bba_pkg::SECTOR_W-1:0] dividend_i,
  input  wire logic [bba_pkg::SPB_W-1:0]    divisor_i,
  output logic                              done_o,
  output logic      [bba_pkg::SECTOR_W-1:0] quotient_o
);
  import bba_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SPB_W-1:0]     dvs_q, rem_q;
  logic [SECTOR_W-1:0]  quo_q;
  logic [SPB_W:0]       trial;
  logic                 fits;

  assign trial = {rem_q, quo_q[SECTOR_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? SPB_W'(trial - {1'b0, dvs_q}) : trial[SPB_W-1:0];
      quo_q <= {quo_q[SECTOR_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

[hdl/bitmap_block_allocator_core.sv]
`default_nettype none
// Allocate: first-fit scan, one bitmap byte per cycle, 1 to MAP_BYTES bytes read,
//   plus the RAM lookup, a multiply (only on success) and the response.
// Free: a bit-serial divide, then a read-modify-write of one byte.
// One item in flight; the next item is taken while the result waits in the output reg.
// Reset (async, active low): control and config regs to defaults, then a clearing pass
//   over the bitmap RAM during which no item is accepted (config writes still land).
module bitmap_block_allocator_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bba_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire bba_pkg::req_t                  in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output bba_pkg::rsp_t                       out_item_o
);
  import bba_pkg::*;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [SECTOR_W-1:0] first_q;
  logic [SPB_W-1:0]    spb_q;
  logic [COUNT_W-1:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      spb_q   <= SPB_W'(1);
      count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FIRST_SECTOR:      first_q <= cfg_wdata_i[SECTOR_W-1:0];
        CFG_SECTORS_PER_BLOCK: spb_q   <= cfg_wdata_i[SPB_W-1:0];
        CFG_BLOCK_COUNT:       count_q <= cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // usable limit and effective divisor (zero sectors per block acts as one)
  logic [COUNT_W-1:0] lim;
  logic [SPB_W-1:0]   spb_div;

  assign lim     = (32'(count_q) > 32'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS) : count_q;
  assign spb_div = (spb_q == '0) ? SPB_W'(1) : spb_q;

  // ---------------------------------------------------------------
  // Bitmap RAM
  // ---------------------------------------------------------------
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;

  bba_ram #(
    .WIDTH (8),
    .DEPTH (MAP_BYTES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------
  // Divider for the free path: (sector - first) / sectors per block
  // ---------------------------------------------------------------
  logic                div_start, div_done;
  logic [SECTOR_W-1:0] div_quo;

  bba_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_item_i.block_sector - first_q),
    .divisor_i  (spb_div),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ---------------------------------------------------------------
  // State and datapath registers
  // ---------------------------------------------------------------
  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  clr_addr_q;
  logic [ADDR_W-1:0]  scan_addr_q;   // next byte address to read
  logic [ADDR_W-1:0]  chk_addr_q;    // address of the byte now on ram_rdata
  logic               chk_vld_q;
  logic [IDX_W-1:0]   idx_q;
  logic [PROD_W-1:0]  prod_q;
  logic               status_q;
  logic               op_q;
  logic               out_valid_q;
  rsp_t               out_item_q;

  logic               in_acc, out_free;
  logic               byte_free, cand_ok, scan_end, quo_ok;
  logic [IDX_W-1:0]   cand_idx;
  logic [2:0]         bit_pos;
  logic [7:0]         idx_mask;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // scan: the byte read last cycle is checked while the next one is fetched
  assign bit_pos   = lowest_zero(ram_rdata);
  assign byte_free = chk_vld_q && (ram_rdata != 8'hFF);
  assign cand_idx  = {chk_addr_q, bit_pos};
  assign cand_ok   = 32'(cand_idx) < 32'(lim);
  assign scan_end  = chk_vld_q && (ram_rdata == 8'hFF)
                     && (chk_addr_q == ADDR_W'(MAP_BYTES - 1));

  // free: quotient must be inside the usable limit
  assign quo_ok   = div_quo < 32'(lim);
  assign idx_mask = 8'(1) << idx_q[2:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:   if (clr_addr_q == ADDR_W'(MAP_BYTES - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) state_d = (in_item_i.operation == OP_FREE) ? ST_DIV : ST_SCAN;
      end
      ST_SCAN: begin
        if (byte_free)     state_d = cand_ok ? ST_MUL : ST_RESP;
        else if (scan_end) state_d = ST_RESP;
      end
      ST_MUL:     state_d = ST_RESP;
      ST_DIV:     if (div_done) state_d = quo_ok ? ST_FREE_RD : ST_RESP;
      ST_FREE_RD: state_d = ST_FREE_WR;
      ST_FREE_WR: state_d = ST_RESP;
      ST_RESP:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // control outputs: handshake, RAM port, divider start
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = scan_addr_q;
    ram_wdata  = ram_rdata;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        div_start  = in_valid_i && (in_item_i.operation == OP_FREE);
      end
      ST_SCAN: begin
        if (byte_free && cand_ok) begin
          // mark the block used; the scan stops here
          ram_we    = 1'b1;
          ram_addr  = chk_addr_q;
          ram_wdata = ram_rdata | (8'(1) << bit_pos);
        end
      end
      ST_FREE_RD: ram_addr = idx_q[IDX_W-1:3];
      ST_FREE_WR: begin
        ram_we    = 1'b1;
        ram_addr  = idx_q[IDX_W-1:3];
        ram_wdata = ram_rdata & ~idx_mask;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      scan_addr_q <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
      if (state_q == ST_IDLE) begin
        scan_addr_q <= '0;
        chk_vld_q   <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        scan_addr_q <= scan_addr_q + 1'b1;  // wraps past the end, harmless
        chk_vld_q   <= 1'b1;
      end
      // a new result may replace the one taken at this edge
      if (state_q == ST_RESP && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)                out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) op_q <= in_item_i.operation;
      end
      ST_SCAN: begin
        chk_addr_q <= scan_addr_q;
        if (byte_free) begin
          idx_q    <= cand_idx;
          status_q <= cand_ok ? STATUS_OK : STATUS_FAIL;
        end else if (scan_end) begin
          status_q <= STATUS_FAIL;
        end
      end
      ST_MUL: prod_q <= {{SPB_W{1'b0}}, idx_q} * {{IDX_W{1'b0}}, spb_div};
      ST_DIV: begin
        if (div_done) begin
          idx_q    <= div_quo[IDX_W-1:0];
          status_q <= quo_ok ? STATUS_OK : STATUS_FAIL;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_item_q.status <= status_q;
          out_item_q.allocated_sector <=
            (status_q == STATUS_FAIL || op_q == OP_FREE) ? '0
                                                         : first_q + SECTOR_W'(prod_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

[hdl/bba_checker.sv]
`default_nettype none
module bba_port_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_ready_o,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire bba_pkg::rsp_t out_item_o
);
  import bba_pkg::*;

  // bitmap clear pass blocks input right after reset
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_o)
    else $error("input ready during clearing pass");

  // a failed request never reports a sector
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == STATUS_FAIL |-> out_item_o.allocated_sector == '0)
    else $error("failed item carries a sector");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // an offered result is fully defined
  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(out_item_o))
    else $error("result carries unknown bits");

endmodule

bind bitmap_block_allocator_core bba_port_checker u_bba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
`default_nettype wire
